FILE: rtl/core/ufd_pkg.sv
// ----------------------------------------------------------------------------
// ufd_pkg: shared types and constants of the uniform double sampler
// Widths of the random word and of the binary64 fields, the exponent limits
// of the geometric extension, and the step record between the sample logic
// and the top level.
// ----------------------------------------------------------------------------
package ufd_pkg;

   localparam int WORD_W  = 64;
   localparam int MANT_W  = 52;
   localparam int EXP_W   = 11;
   localparam int TOP_W   = WORD_W - MANT_W;   // bits above the mantissa
   localparam int LZ_W    = 7;                 // leading-zero count 0..64
   localparam int COUNT_W = 11;

   // count at which the extension is cut short
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = 11'd1022;
   // extension count from which the exponent reaches the bias (13 + 1010)
   localparam logic [COUNT_W-1:0] SUB_COUNT   = 11'd1010;
   // exponent field of an immediate sample: 1023 - (lz + 1)
   localparam logic [EXP_W-1:0]   IMM_EXP_TOP = 11'd1022;
   // exponent field of an extended sample: 1023 - (13 + count)
   localparam logic [EXP_W-1:0]   EXT_EXP_TOP = 11'd1010;
   // binary64 pattern of 1.0
   localparam logic [WORD_W-1:0]  ONE_BITS    = 64'h3FF0_0000_0000_0000;

   // what one request does to the sampler state
   typedef struct packed {
      logic               emit;
      logic               extend_next;
      logic [COUNT_W-1:0] count_next;
   } step_type;

endpackage

FILE: rtl/core/ufd_lzc.sv
// ----------------------------------------------------------------------------
// ufd_lzc: 64-bit leading-zero counter
// Halving search down to one nibble, then a nibble table. All-zero gives 64.
// ----------------------------------------------------------------------------
module ufd_lzc (
   input  logic [ufd_pkg::WORD_W-1:0] word,
   output logic [ufd_pkg::LZ_W-1:0]   lz
);
   import ufd_pkg::*;

   // leading zeros of a nibble, indexed by its value
   localparam logic [2:0] NIBBLE_LZ [16] = '{
      3'd4, 3'd3, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
   };

   logic [LZ_W-1:0]   base;
   logic [WORD_W-1:0] v;

   // four halving steps, then the table on the last nibble
   always_comb begin
      base = 7'd60;
      v    = word;
      if (v[63:32] != '0) begin
         base = base - 7'd32;
         v    = {32'b0, v[63:32]};
      end
      if (v[31:16] != '0) begin
         base = base - 7'd16;
         v    = {48'b0, v[31:16]};
      end
      if (v[15:8] != '0) begin
         base = base - 7'd8;
         v    = {56'b0, v[15:8]};
      end
      if (v[7:4] != '0) begin
         base = base - 7'd4;
         v    = {60'b0, v[7:4]};
      end
      lz = base + {4'b0, NIBBLE_LZ[v[3:0]]};
   end

endmodule

FILE: rtl/core/ufd_sample.sv
// ----------------------------------------------------------------------------
// ufd_sample: one step of the sampler
// From a registered random word and the current extension state, works out
// the binary64 pattern, the subnormal flag and the next state.
// ----------------------------------------------------------------------------
module ufd_sample (
   input  logic [ufd_pkg::WORD_W-1:0]  word,
   input  logic                        extending,
   input  logic [ufd_pkg::MANT_W-1:0]  held_mantissa,
   input  logic [ufd_pkg::COUNT_W-1:0] count,
   output ufd_pkg::step_type           step,
   output logic [ufd_pkg::WORD_W-1:0]  sample_bits,
   output logic                        is_subnormal
);
   import ufd_pkg::*;

   logic [LZ_W-1:0]    lz;
   logic [MANT_W-1:0]  mant;
   logic [COUNT_W-1:0] count_sum;
   logic [EXP_W-1:0]   exp_field;
   logic               sub_range;

   // leading zeros of the whole word; for a new sample with a nonzero top
   // field this equals the leading zeros of the top 12 bits
   ufd_lzc u_lzc (
      .word (word),
      .lz   (lz)
   );

   // next state and exponent
   always_comb begin
      mant      = extending ? held_mantissa : word[MANT_W-1:0];
      count_sum = count + {{(COUNT_W-LZ_W){1'b0}}, lz};
      if (!extending) begin
         step.emit        = (word[WORD_W-1:MANT_W] != '0);
         step.extend_next = !step.emit;
         step.count_next  = '0;
         sub_range        = 1'b0;
         exp_field        = IMM_EXP_TOP - {{(EXP_W-LZ_W){1'b0}}, lz};
      end else begin
         step.emit        = (word != '0) || (count_sum >= COUNT_LIMIT);
         step.extend_next = !step.emit;
         step.count_next  = count_sum;
         sub_range        = (count_sum >= SUB_COUNT);
         exp_field        = EXT_EXP_TOP - count_sum;
      end
   end

   // pattern assembly; a zero pattern becomes 1.0
   always_comb begin
      if (sub_range) begin
         if (mant == '0) begin
            sample_bits  = ONE_BITS;
            is_subnormal = 1'b0;
         end else begin
            sample_bits  = {{TOP_W{1'b0}}, mant};
            is_subnormal = 1'b1;
         end
      end else begin
         sample_bits  = {1'b0, exp_field, mant};
         is_subnormal = 1'b0;
      end
   end

endmodule

FILE: rtl/core/uniform_double_from_random_bits_top.sv
// ----------------------------------------------------------------------------
// uniform_double_from_random_bits_top: uniform binary64 sampler on (0,1]
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------
//   req     | in        | req_valid, req_stall, req_random_word
//   rsp     | out       | rsp_valid, rsp_stall, rsp_sample_bits,
//           |           | rsp_is_subnormal
//
// One request is taken every cycle while req_stall is low; a sample leaves
// through the request register, then the result register. Requests whose top
// 12 bits are zero open a geometric extension
// and give no result until the extension ends.
// Reset (synchronous) empties both registers and clears the extension state.
// A stalled result blocks a new step only when the step would emit.
// ----------------------------------------------------------------------------
module uniform_double_from_random_bits_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ufd_pkg::WORD_W-1:0]  req_random_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ufd_pkg::WORD_W-1:0]  rsp_sample_bits,
   output logic                        rsp_is_subnormal
);
   import ufd_pkg::*;

   logic                 in_valid_ff;
   logic [WORD_W-1:0]    in_word_ff;
   logic                 extending_ff;
   logic [MANT_W-1:0]    held_mant_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 out_valid_ff;
   logic [WORD_W-1:0]    out_bits_ff;
   logic                 out_sub_ff;

   step_type             step;
   logic [WORD_W-1:0]    sample_bits;
   logic                 is_subnormal;
   logic                 out_free;
   logic                 advance;
   logic                 out_valid_in;

   ufd_sample u_sample (
      .word          (in_word_ff),
      .extending     (extending_ff),
      .held_mantissa (held_mant_ff),
      .count         (count_ff),
      .step          (step),
      .sample_bits   (sample_bits),
      .is_subnormal  (is_subnormal)
   );

   // flow control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!step.emit || out_free);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance && step.emit) begin
         out_valid_in = 1'b1;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_word_ff <= req_random_word;
      end
   end

   // extension state
   always_ff @(posedge clock) begin
      if (reset) begin
         extending_ff <= 1'b0;
         count_ff     <= '0;
      end else if (advance) begin
         extending_ff <= step.extend_next;
         count_ff     <= step.count_next;
      end
      if (advance && !extending_ff) begin
         held_mant_ff <= in_word_ff[MANT_W-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance && step.emit) begin
         out_bits_ff <= sample_bits;
         out_sub_ff  <= is_subnormal;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sample_bits  = out_bits_ff;
   assign rsp_is_subnormal = out_sub_ff;

`ifndef NO_ASSERTIONS
   // an open extension never holds a count at the cut-off
   assert property (@(posedge clock) disable iff (reset)
      extending_ff |-> (count_ff < COUNT_LIMIT))
      else $error("extension count reached the limit while still open");

   // a subnormal result has a zero exponent and sign
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_subnormal) |-> (rsp_sample_bits[WORD_W-1:MANT_W] == '0))
      else $error("subnormal flag with nonzero exponent field");

   // a zero pattern is never delivered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_bits != '0))
      else $error("zero pattern delivered");

   // the request side stalls only with a word in hand that cannot move
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && step.emit && out_valid_ff && rsp_stall))
      else $error("request stalled without a blocked result");
`endif

endmodule

FILE: test/ufd_sample_checker.sv
// ----------------------------------------------------------------------------
// ufd_sample_checker: scoreboard for the uniform double sampler
// Watches the request and result channels. It keeps its own copy of the
// extension state, works out the binary64 pattern that each completed sample
// should give, and compares every accepted result field by field with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ufd_sample_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [ufd_pkg::WORD_W-1:0]  req_random_word,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [ufd_pkg::WORD_W-1:0]  rsp_sample_bits,
   input  logic                        rsp_is_subnormal,
   output int                          mismatch_count,
   output int                          pending_samples
);

   localparam int unsigned EXP_BIAS = 1023;
   // exponent magnitude at the start of an extension: one past the top field
   localparam int unsigned EXT_BASE = ufd_pkg::TOP_W + 1;

   typedef struct packed {
      logic [ufd_pkg::WORD_W-1:0] bits;
      logic                       subnormal;
   } sample_type;

   sample_type                  expected_samples[$];
   logic                        extending_q;
   logic [ufd_pkg::MANT_W-1:0]  mant_q;
   logic [ufd_pkg::COUNT_W-1:0] count_q;

   // leading zeros of a full word, 64 for zero
   function automatic logic [ufd_pkg::LZ_W-1:0] count_lead_zeros(
      input logic [ufd_pkg::WORD_W-1:0] w);
      logic [ufd_pkg::LZ_W-1:0] n;
      int i;
      n = ufd_pkg::LZ_W'(ufd_pkg::WORD_W);
      for (i = 0; i < ufd_pkg::WORD_W; i++) begin
         if (w[i]) begin
            n = ufd_pkg::LZ_W'(ufd_pkg::WORD_W - 1 - i);
         end
      end
      return n;
   endfunction

   // binary64 pattern for a mantissa and an exponent magnitude
   function automatic sample_type build_sample(input logic [ufd_pkg::MANT_W-1:0] mant,
                                               input int unsigned expo);
      sample_type s;
      if (expo >= EXP_BIAS) begin
         s.bits      = {{(ufd_pkg::TOP_W){1'b0}}, mant};
         s.subnormal = 1'b1;
      end else begin
         s.bits      = {1'b0, ufd_pkg::EXP_W'(EXP_BIAS - expo), mant};
         s.subnormal = 1'b0;
      end
      // a zero pattern becomes 1.0
      if (s.bits == '0) begin
         s.bits      = ufd_pkg::ONE_BITS;
         s.subnormal = 1'b0;
      end
      return s;
   endfunction

   // advance the predicted state by one accepted request
   task automatic take_word(input logic [ufd_pkg::WORD_W-1:0] w);
      logic [ufd_pkg::LZ_W-1:0] lz;
      lz = count_lead_zeros(w);
      if (!extending_q) begin
         if (w[ufd_pkg::WORD_W-1:ufd_pkg::MANT_W] != '0) begin
            expected_samples.push_back(build_sample(w[ufd_pkg::MANT_W-1:0], lz + 1));
         end else begin
            mant_q      = w[ufd_pkg::MANT_W-1:0];
            count_q     = '0;
            extending_q = 1'b1;
         end
      end else begin
         count_q = count_q + ufd_pkg::COUNT_W'(lz);
         if (w != '0 || count_q >= ufd_pkg::COUNT_LIMIT) begin
            extending_q = 1'b0;
            expected_samples.push_back(build_sample(mant_q, EXT_BASE + count_q));
         end
      end
   endtask

   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         extending_q    = 1'b0;
         mant_q         = '0;
         count_q        = '0;
         mismatch_count = 0;
         expected_samples.delete();
      end else begin
         // results first: none can come from a request taken at this edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected sample_bits %h is_subnormal %b",
                      rsp_sample_bits, rsp_is_subnormal);
               mismatch_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample_bits !== want.bits) begin
                  $error("sample_bits: expected %h, actual %h", want.bits, rsp_sample_bits);
                  mismatch_count++;
               end
               if (rsp_is_subnormal !== want.subnormal) begin
                  $error("is_subnormal: expected %b, actual %b",
                         want.subnormal, rsp_is_subnormal);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            take_word(req_random_word);
         end
      end
      pending_samples = expected_samples.size();
   end

endmodule

FILE: test/uniform_double_from_random_bits_top_tb.sv
// ----------------------------------------------------------------------------
// uniform_double_from_random_bits_top_tb: testbench of the sampler top level
// Sends directed words for every exponent of an immediate sample and for
// short extensions, then random sequences: immediate samples, short and long
// geometric extensions (reaching the subnormal range and the count cut-off)
// and plain noise. Both sides idle at random; once the result side holds off
// for a long stretch. A separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module uniform_double_from_random_bits_top_tb;

   localparam int ITEM_TARGET    = 650;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLD_AT_SEQ    = 60;

   typedef enum int {
      SEQ_IMMEDIATE,
      SEQ_SHORT_EXT,
      SEQ_LONG_EXT,
      SEQ_NOISE
   } seq_kind_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [ufd_pkg::WORD_W-1:0]  req_random_word;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [ufd_pkg::WORD_W-1:0]  rsp_sample_bits;
   logic                        rsp_is_subnormal;
   int                          mismatch_count;
   int                          pending_samples;

   int sent_items;
   int idle_cycles;
   bit hold_off_req;
   int send_left;
   bit send_eager;
   int recv_left;
   bit recv_eager;

   always #5 clock = ~clock;

   uniform_double_from_random_bits_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_random_word  (req_random_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_bits  (rsp_sample_bits),
      .rsp_is_subnormal (rsp_is_subnormal)
   );

   ufd_sample_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_random_word  (req_random_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_bits  (rsp_sample_bits),
      .rsp_is_subnormal (rsp_is_subnormal),
      .mismatch_count   (mismatch_count),
      .pending_samples  (pending_samples)
   );

   // wait before the next request or result; runs of no waiting now and then
   function automatic int draw_wait(inout int left, inout bit eager);
      if (left == 0) begin
         eager = ($urandom_range(0, 3) == 0);
         left  = $urandom_range(10, 40);
      end
      left--;
      return eager ? 0 : $urandom_range(0, 8);
   endfunction

   // random word with exactly n leading zeros (zero word for n = 64)
   function automatic logic [ufd_pkg::WORD_W-1:0] word_with_lead_zeros(input int n);
      logic [ufd_pkg::WORD_W-1:0] r;
      logic [ufd_pkg::WORD_W-1:0] msb;
      if (n >= ufd_pkg::WORD_W) begin
         return '0;
      end
      r   = {$urandom, $urandom};
      msb = 64'h1 << (ufd_pkg::WORD_W - 1 - n);
      return msb | (r & (msb - 1));
   endfunction

   // word that opens an extension; a zero mantissa now and then
   function automatic logic [ufd_pkg::WORD_W-1:0] extension_start();
      logic [ufd_pkg::WORD_W-1:0] r;
      r = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) begin
         return '0;
      end
      return {{(ufd_pkg::TOP_W){1'b0}}, r[ufd_pkg::MANT_W-1:0]};
   endfunction

   // offer one request and wait for it to be taken
   task automatic send_word(input logic [ufd_pkg::WORD_W-1:0] w);
      int gap;
      gap = draw_wait(send_left, send_eager);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_random_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   // request side: directed words, random sequences, drain, verdict
   initial begin
      int seq_count;
      int pick;
      int k;
      seq_kind_type kind;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_random_word <= '0;
      sent_items   = 0;
      hold_off_req = 1'b0;
      send_left    = 0;
      seq_count    = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // immediate samples, one per leading-zero count of the top field
      send_word('1);
      for (k = 1; k < ufd_pkg::TOP_W - 1; k++) begin
         send_word(word_with_lead_zeros(k));
      end
      send_word(64'h0010_0000_0000_0000);
      // all-zero word opens an extension that an all-ones word ends at once
      send_word('0);
      send_word('1);
      // extension ended by the smallest nonzero word
      send_word({{(ufd_pkg::TOP_W){1'b0}}, {(ufd_pkg::MANT_W){1'b1}}});
      send_word(64'h1);

      // random sequences
      while (sent_items < ITEM_TARGET) begin
         seq_count++;
         if (seq_count == HOLD_AT_SEQ) begin
            hold_off_req = 1'b1;
         end
         pick = $urandom_range(0, 19);
         if (pick < 9) begin
            kind = SEQ_IMMEDIATE;
         end else if (pick < 15) begin
            kind = SEQ_SHORT_EXT;
         end else if (pick < 17) begin
            kind = SEQ_LONG_EXT;
         end else begin
            kind = SEQ_NOISE;
         end
         case (kind)
            SEQ_IMMEDIATE: begin
               send_word(word_with_lead_zeros($urandom_range(0, ufd_pkg::TOP_W - 1)));
            end
            SEQ_SHORT_EXT: begin
               send_word(extension_start());
               repeat ($urandom_range(0, 3)) begin
                  send_word(word_with_lead_zeros($urandom_range(0, ufd_pkg::WORD_W)));
               end
            end
            SEQ_LONG_EXT: begin
               // 15 zero words take the count near the subnormal range, 16 past the cut-off
               send_word(extension_start());
               repeat ($urandom_range(14, 16)) send_word('0);
               if ($urandom_range(0, 1) == 0) begin
                  send_word(word_with_lead_zeros($urandom_range(48, ufd_pkg::WORD_W - 1)));
               end else begin
                  send_word(word_with_lead_zeros($urandom_range(0, ufd_pkg::WORD_W - 1)));
               end
            end
            default: begin
               send_word({$urandom, $urandom});
            end
         endcase
      end
      req_valid <= 1'b0;

      // drain, then allow the pipeline latency to settle
      @(posedge clock);
      while (pending_samples != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int gap;
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      recv_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = draw_wait(recv_left, recv_eager);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // watchdog: too long without any handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
